### hdl/jmba_pkg.sv
// Shared types and constants for the JTAG master bus access unit.
package jmba_pkg;

    localparam int CODE_W          = 6;
    localparam int ADDR_W          = 32;
    localparam int DATA_W          = 32;
    localparam int SEND_W          = 35;
    localparam int COUNT_W         = 6;
    localparam int CFG_IDX_W       = 2;
    localparam int IR_BITS_DEFAULT = 6;
    localparam int QDEPTH          = 2;

    localparam logic [1:0]         SIZE_WORD       = 2'h2;
    localparam logic [COUNT_W-1:0] CMD_SHIFT_BITS  = 6'd35;
    localparam logic [COUNT_W-1:0] DATA_SHIFT_BITS = 6'd33;

    localparam logic [CODE_W-1:0] USER1_RESET = 6'd2;
    localparam logic [CODE_W-1:0] USER2_RESET = 6'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_USER1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER2 = 2'd1;

    typedef struct packed {
        logic              op;
        logic              button_reset;
        logic              tdo_bit;
        logic [ADDR_W-1:0] cmd_address;
        logic              cmd_write;
        logic [DATA_W-1:0] cmd_wdata;
    } in_item_t;

    typedef struct packed {
        logic              trst_n;
        logic              tms_pin;
        logic              tdi_pin;
        logic [DATA_W-1:0] read_word;
        logic              read_ready;
        logic              busy_res;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_CMD  = 2'd1,
        KIND_BRST = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              tdo_bit;
        logic [ADDR_W-1:0] cmd_address;
        logic              cmd_write;
        logic [DATA_W-1:0] cmd_wdata;
    } req_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CODE_W-1:0]    data;
    } cfg_wr_t;

    typedef enum logic [7:0] {
        TAP_RESET   = 8'b0000_0001,
        TAP_IDLE    = 8'b0000_0010,
        TAP_SEL_DR  = 8'b0000_0100,
        TAP_SEL_IR  = 8'b0000_1000,
        TAP_CAPTURE = 8'b0001_0000,
        TAP_SHIFT   = 8'b0010_0000,
        TAP_EXIT1   = 8'b0100_0000,
        TAP_UPDATE  = 8'b1000_0000
    } tap_state_t;

endpackage

### hdl/jtag_master_bus_access_unit.sv
// Top level of the JTAG master bus access unit: request queue plus TAP sequencer.
//
//   channel   direction  handshake             payload
//   in        request    in_valid / in_stall   in_data  (in_item_t)
//   out       result     out_valid / out_stall out_data (out_item_t)
//   cfg       write      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Every request (tick, command load or button reset) yields exactly one result.
// A request passes from acceptance through the front queue, then through the TAP
// sequencer into the result register; one request per cycle is sustained while
// the result is not stalled.
// Reset puts the TAP sequencer in test-logic-reset with trst_n low, tms/tdi high.
// A stalled result holds the sequencer; the two-entry queue then absorbs
// requests until it fills and raises in_stall.
module jtag_master_bus_access_unit
    import jmba_pkg::*;
#(
    parameter int IR_BITS = IR_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data
);

    logic    q_valid;
    req_t    q_req;
    logic    q_pop;
    cfg_wr_t cfg_wr;

    // User must land configuration writes while idle; unenforced, taken at once.
    assign cfg_ready    = 1'b1;
    assign cfg_wr.we    = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // Classify each request and park it until the sequencer is free.
    jmba_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop)
    );

    // Advance the TAP one edge per tick, latch commands, register the result.
    jmba_engine #(
        .IR_BITS (IR_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### hdl/jmba_front.sv
// Front end: classify incoming requests and hold them in a short queue.
module jmba_front
    import jmba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     q_valid,
    output req_t     q_req,
    input  logic     q_pop
);

    localparam int PTR_W = $clog2(QDEPTH);

    req_t             mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             push;
    req_t             req_in;

    always_comb
    begin
        req_in.tdo_bit     = in_data.tdo_bit;
        req_in.cmd_address = in_data.cmd_address;
        req_in.cmd_write   = in_data.cmd_write;
        req_in.cmd_wdata   = in_data.cmd_wdata;
        if (in_data.op)
            req_in.kind = KIND_CMD;
        else if (in_data.button_reset)
            req_in.kind = KIND_BRST;
        else
            req_in.kind = KIND_TICK;
    end

    assign in_stall = (count_reg == (PTR_W+1)'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_req    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (q_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !q_pop)
            count_next = count_reg + 1'b1;
        else if (!push && q_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= req_in;
    end

endmodule

### hdl/jmba_engine.sv
// Back end: TAP controller sequencer, shift registers and result register.
module jmba_engine
    import jmba_pkg::*;
#(
    parameter int IR_BITS = IR_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_wr_t   cfg_wr,
    input  logic      q_valid,
    input  req_t      q_req,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic [CODE_W-1:0]  user1_reg;
    logic [CODE_W-1:0]  user2_reg;
    tap_state_t         tap_reg, tap_next;
    logic               in_ir_reg, in_ir_next;
    logic               sel2_reg, sel2_next;
    logic [SEND_W-1:0]  send_reg, send_next;
    logic [DATA_W-1:0]  capture_reg, capture_next;
    logic [DATA_W-1:0]  captured_reg, captured_next;
    logic               ready_reg, ready_next;
    logic [COUNT_W-1:0] bits_reg, bits_next;
    logic               pending_reg, pending_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               write_reg, write_next;
    logic [DATA_W-1:0]  wdata_reg, wdata_next;
    logic               trst_reg, trst_next;
    logic               tms_reg, tms_next;
    logic               tdi_reg, tdi_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;
    logic               data_phase;

    assign q_pop      = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;
    assign data_phase = !in_ir_reg && sel2_reg;

    always_comb
    begin
        tap_next      = tap_reg;
        in_ir_next    = in_ir_reg;
        sel2_next     = sel2_reg;
        send_next     = send_reg;
        capture_next  = capture_reg;
        captured_next = captured_reg;
        ready_next    = ready_reg;
        bits_next     = bits_reg;
        pending_next  = pending_reg;
        addr_next     = addr_reg;
        write_next    = write_reg;
        wdata_next    = wdata_reg;
        trst_next     = trst_reg;
        tms_next      = tms_reg;
        tdi_next      = tdi_reg;

        if (q_pop)
        begin
            unique case (q_req.kind)
                KIND_CMD:
                begin
                    // drop the command while an access is still running
                    if (!pending_reg)
                    begin
                        addr_next    = q_req.cmd_address;
                        write_next   = q_req.cmd_write;
                        wdata_next   = q_req.cmd_wdata;
                        pending_next = 1'b1;
                    end
                end
                KIND_BRST:
                begin
                    tap_next     = TAP_RESET;
                    trst_next    = 1'b0;
                    tms_next     = 1'b1;
                    tdi_next     = 1'b1;
                    pending_next = 1'b0;
                    ready_next   = 1'b0;
                end
                KIND_TICK:
                begin
                    trst_next = 1'b1;
                    tdi_next  = 1'b1;
                    if (tap_reg == TAP_SHIFT)
                    begin
                        tdi_next  = send_reg[0];
                        send_next = send_reg >> 1;
                    end
                    if (data_phase && tap_reg == TAP_SHIFT)
                        capture_next = {q_req.tdo_bit, capture_reg[DATA_W-1:1]};
                    if (data_phase && tap_reg == TAP_UPDATE)
                    begin
                        ready_next    = 1'b1;
                        captured_next = capture_reg;
                    end

                    unique case (tap_reg)
                        TAP_RESET:
                        begin
                            tms_next = 1'b0;
                            tap_next = TAP_IDLE;
                        end
                        TAP_IDLE:
                        begin
                            tms_next = pending_reg;
                            if (pending_reg)
                            begin
                                tap_next   = TAP_SEL_DR;
                                sel2_next  = 1'b0;
                                in_ir_next = 1'b1;
                            end
                        end
                        TAP_SEL_DR:
                        begin
                            tms_next = in_ir_reg;
                            tap_next = in_ir_reg ? TAP_SEL_IR : TAP_CAPTURE;
                        end
                        TAP_SEL_IR:
                        begin
                            tms_next = 1'b0;
                            tap_next = TAP_CAPTURE;
                        end
                        TAP_CAPTURE:
                        begin
                            if (in_ir_reg)
                                send_next = SEND_W'(sel2_reg ? user2_reg : user1_reg);
                            else if (!sel2_reg)
                                send_next = {write_reg, SIZE_WORD, addr_reg};
                            else
                                send_next = {3'b001, wdata_reg};
                            tms_next = 1'b0;
                            tap_next = TAP_SHIFT;
                            if (in_ir_reg)
                                bits_next = COUNT_W'(IR_BITS);
                            else if (!sel2_reg)
                                bits_next = CMD_SHIFT_BITS;
                            else
                                bits_next = DATA_SHIFT_BITS;
                        end
                        TAP_SHIFT:
                        begin
                            if (bits_reg > COUNT_W'(1))
                            begin
                                bits_next = bits_reg - 1'b1;
                                tms_next  = 1'b0;
                            end
                            else
                            begin
                                bits_next = '0;
                                tms_next  = 1'b1;
                                tap_next  = TAP_EXIT1;
                            end
                        end
                        TAP_EXIT1:
                        begin
                            tms_next = 1'b1;
                            tap_next = TAP_UPDATE;
                        end
                        TAP_UPDATE:
                        begin
                            if (in_ir_reg)
                            begin
                                in_ir_next = 1'b0;
                                tms_next   = 1'b1;
                                tap_next   = TAP_SEL_DR;
                            end
                            else if (!sel2_reg)
                            begin
                                in_ir_next = 1'b1;
                                sel2_next  = 1'b1;
                                tms_next   = 1'b1;
                                tap_next   = TAP_SEL_DR;
                            end
                            else
                            begin
                                tms_next     = 1'b0;
                                tap_next     = TAP_IDLE;
                                pending_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            tap_next = TAP_RESET;
                        end
                    endcase
                end
                default:
                begin
                    tap_next = tap_reg;
                end
            endcase
        end

        out_next.trst_n     = trst_next;
        out_next.tms_pin    = tms_next;
        out_next.tdi_pin    = tdi_next;
        out_next.read_word  = captured_next;
        out_next.read_ready = ready_next;
        out_next.busy_res   = pending_next;

        if (q_pop)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user1_reg     <= USER1_RESET;
            user2_reg     <= USER2_RESET;
            tap_reg       <= TAP_RESET;
            in_ir_reg     <= 1'b0;
            sel2_reg      <= 1'b0;
            capture_reg   <= '0;
            captured_reg  <= '0;
            ready_reg     <= 1'b0;
            bits_reg      <= '0;
            pending_reg   <= 1'b0;
            addr_reg      <= '0;
            write_reg     <= 1'b0;
            wdata_reg     <= '0;
            trst_reg      <= 1'b0;
            tms_reg       <= 1'b1;
            tdi_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr.we)
            begin
                case (cfg_wr.index)
                    CFG_USER1: user1_reg <= cfg_wr.data;
                    CFG_USER2: user2_reg <= cfg_wr.data;
                    default:   user1_reg <= user1_reg;
                endcase
            end
            tap_reg       <= tap_next;
            in_ir_reg     <= in_ir_next;
            sel2_reg      <= sel2_next;
            capture_reg   <= capture_next;
            captured_reg  <= captured_next;
            ready_reg     <= ready_next;
            bits_reg      <= bits_next;
            pending_reg   <= pending_next;
            addr_reg      <= addr_next;
            write_reg     <= write_next;
            wdata_reg     <= wdata_next;
            trst_reg      <= trst_next;
            tms_reg       <= tms_next;
            tdi_reg       <= tdi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        send_reg <= send_next;
        if (q_pop)
            out_reg <= out_next;
    end

endmodule

### hdl/jmba_checker.sv
// Port-level checks for the JTAG master bus access unit and their bind.
module jmba_checker
    import jmba_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // TAP reset drives tms and tdi high.
    a_reset_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.trst_n |-> out_data.tms_pin && out_data.tdi_pin)
        else $error("reset pins not forced high");

    // Ready flag is cleared whenever the TAP is held in reset.
    a_reset_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.trst_n |-> !out_data.read_ready)
        else $error("ready flag set during TAP reset");

    // TDI only goes low while an access is shifting.
    a_tdi_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.tdi_pin |-> out_data.busy_res)
        else $error("tdi low with no access in progress");

endmodule

bind jtag_master_bus_access_unit jmba_checker u_jmba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
